// ----- src/range_calibration_interp_assert.svh -----
// ----------------------------------------------------------------------------
// Range calibration assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef RANGE_CALIBRATION_INTERP_ASSERT_SVH
`define RANGE_CALIBRATION_INTERP_ASSERT_SVH

// Same-cycle implication.
`define RCI_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RCI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rci_pkg.sv -----
// ----------------------------------------------------------------------------
// Range calibration package
// Breakpoint tables, datapath widths and sequencer states.
// ----------------------------------------------------------------------------
package rci_pkg;

	localparam int STORED_POINTS = 41;
	localparam int IDX_W = 6;
	localparam int RAW_W = 16;
	localparam int DX_W = 6;
	localparam int DY_W = 7;
	localparam int PROD_W = RAW_W + DY_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int CNT_W = $clog2(PROD_W);

	localparam logic [RAW_W-1:0] BP_RAW [STORED_POINTS] = '{
		16'd131, 16'd192, 16'd201, 16'd222, 16'd235, 16'd258, 16'd289, 16'd314,
		16'd337, 16'd358, 16'd378, 16'd397, 16'd416, 16'd434, 16'd450, 16'd465,
		16'd480, 16'd496, 16'd507, 16'd520, 16'd536, 16'd544, 16'd557, 16'd568,
		16'd577, 16'd586, 16'd595, 16'd604, 16'd612, 16'd621, 16'd629, 16'd636,
		16'd644, 16'd650, 16'd658, 16'd664, 16'd670, 16'd676, 16'd682, 16'd689,
		16'd694
	};

	localparam logic [RAW_W-1:0] BP_TRUE [STORED_POINTS] = '{
		16'd135, 16'd235, 16'd240, 16'd280, 16'd300, 16'd340, 16'd400, 16'd450,
		16'd500, 16'd550, 16'd600, 16'd650, 16'd700, 16'd750, 16'd800, 16'd850,
		16'd900, 16'd950, 16'd1000, 16'd1050, 16'd1100, 16'd1150, 16'd1200, 16'd1250,
		16'd1300, 16'd1350, 16'd1400, 16'd1450, 16'd1500, 16'd1550, 16'd1600, 16'd1650,
		16'd1700, 16'd1750, 16'd1800, 16'd1850, 16'd1900, 16'd1950, 16'd2000, 16'd2050,
		16'd2100
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

// ----- src/range_calibration_interp.sv -----
// ----------------------------------------------------------------------------
// Range calibration interpolator
// Converts a raw range reading to a calibrated distance by piecewise-linear
// interpolation over a fixed breakpoint table, with a serial segment search
// and a restoring divider.
// ----------------------------------------------------------------------------
// Channel  Ports                                      Handshake
// input    raw_distance                               start high, busy low
// output   true_distance, below_range, saturated      done high, one cycle
//
// A reading in segment s passes through the segment search (one breakpoint a
// cycle, from segment 0 up to s), a multiply step, the 23-step divider and a
// finish step before done. A reading below the first breakpoint is
// answered in the cycle after accept. Reset clears the sequencer and the
// strobe. The receiver cannot stall; busy holds new items off.
// ----------------------------------------------------------------------------
`include "range_calibration_interp_assert.svh"

module range_calibration_interp
	import rci_pkg::*;
#(
	parameter int TABLE_POINTS = 41
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [RAW_W-1:0]  raw_distance,
	output logic              done,
	output logic [RAW_W-1:0]  true_distance,
	output logic              below_range,
	output logic              saturated
);

	localparam int N_USE = (TABLE_POINTS < 2) ? 2 :
		((TABLE_POINTS > STORED_POINTS) ? STORED_POINTS : TABLE_POINTS);
	localparam logic [IDX_W-1:0] LAST_SEG = IDX_W'(N_USE - 2);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(PROD_W - 1);

	state_t state_q, state_d;
	logic [RAW_W-1:0] raw_q;
	logic [IDX_W-1:0] seg_q;
	logic [DX_W-1:0] dx_q;
	logic [DX_W-1:0] rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic done_q;
	logic [RAW_W-1:0] true_q;
	logic below_q;
	logic sat_q;

	logic accept;
	logic [IDX_W-1:0] seg_nx;
	logic hit;
	logic [RAW_W-1:0] x0, x1, y0, y1;
	logic [RAW_W-1:0] diff;
	logic [DY_W-1:0] dy;
	logic [PROD_W-1:0] prod;
	logic [DX_W:0] trial;
	logic take;
	logic [SUM_W-1:0] sum;

	assign accept = start && (state_q == ST_IDLE);
	assign seg_nx = IDX_W'(seg_q + 1'b1);
	assign x0 = BP_RAW[seg_q];
	assign x1 = BP_RAW[seg_nx];
	assign y0 = BP_TRUE[seg_q];
	assign y1 = BP_TRUE[seg_nx];
	assign hit = (raw_q < x1) || (seg_q == LAST_SEG);
	assign diff = raw_q - x0;
	assign dy = DY_W'(y1 - y0);
	assign prod = {{DY_W{1'b0}}, diff} * {{RAW_W{1'b0}}, dy};
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign take = trial >= {1'b0, dx_q};
	assign sum = {1'b0, quo_q} + {{(SUM_W-RAW_W){1'b0}}, y0};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (raw_distance >= BP_RAW[0])) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (hit) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_DIV;
			ST_DIV: begin
				if (cnt_q == DIV_LAST) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= (accept && (raw_distance < BP_RAW[0])) || (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					raw_q <= raw_distance;
					seg_q <= '0;
					true_q <= BP_TRUE[0];
					below_q <= 1'b1;
					sat_q <= 1'b0;
				end
			end
			ST_SEARCH: begin
				if (!hit) begin
					seg_q <= seg_nx;
				end
			end
			ST_MUL: begin
				quo_q <= prod;
				dx_q <= DX_W'(x1 - x0);
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= take ? DX_W'(trial - {1'b0, dx_q}) : DX_W'(trial);
				quo_q <= {quo_q[PROD_W-2:0], take};
				cnt_q <= CNT_W'(cnt_q + 1'b1);
			end
			ST_FIN: begin
				below_q <= 1'b0;
				sat_q <= |sum[SUM_W-1:RAW_W];
				true_q <= (|sum[SUM_W-1:RAW_W]) ? {RAW_W{1'b1}} : sum[RAW_W-1:0];
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign true_distance = true_q;
	assign below_range = below_q;
	assign saturated = sat_q;

	`RCI_ASSERT_NEXT(a_fin_done, state_q == ST_FIN, done && !busy,
		"finish step did not deliver a result")
	`RCI_ASSERT_NEXT(a_below_fast, start && !busy && (raw_distance < BP_RAW[0]),
		done && below_range, "below-range item not answered at once")
	`RCI_ASSERT_NOW(a_below_value, done && below_range,
		!saturated && (true_distance == BP_TRUE[0]), "below-range result is wrong")
	`RCI_ASSERT_NOW(a_rem_bound, state_q == ST_DIV, rem_q < dx_q,
		"divider remainder not below divisor")

endmodule

// ----- bench/tb_range_calibration_interp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range calibration interpolator testbench
// Sends raw range readings through the start/busy handshake with random
// gaps and checks every done strobe against a local piecewise-linear model
// of the calibration table, including the below-range and saturation flags.
// ----------------------------------------------------------------------------
module tb_range_calibration_interp
	import rci_pkg::*;
();

	localparam int CAL_POINTS = 41;
	localparam int unsigned OUT_LIMIT = 65535;
	localparam int DIRECTED_COUNT = 24;
	localparam int RANDOM_COUNT = 1450;

	localparam int unsigned CAL_RAW [CAL_POINTS] = '{
		131, 192, 201, 222, 235, 258, 289, 314, 337, 358,
		378, 397, 416, 434, 450, 465, 480, 496, 507, 520,
		536, 544, 557, 568, 577, 586, 595, 604, 612, 621,
		629, 636, 644, 650, 658, 664, 670, 676, 682, 689,
		694
	};

	localparam int unsigned CAL_TRUE [CAL_POINTS] = '{
		135, 235, 240, 280, 300, 340, 400, 450, 500, 550,
		600, 650, 700, 750, 800, 850, 900, 950, 1000, 1050,
		1100, 1150, 1200, 1250, 1300, 1350, 1400, 1450, 1500, 1550,
		1600, 1650, 1700, 1750, 1800, 1850, 1900, 1950, 2000, 2050,
		2100
	};

	localparam int unsigned DIRECTED_RAW [DIRECTED_COUNT] = '{
		0, 1, 130, 131, 132, 191, 192, 193, 200, 201,
		400, 688, 689, 693, 694, 695, 1000, 7037, 7038, 7039,
		21845, 43690, 65534, 65535
	};

	typedef struct {
		logic [RAW_W-1:0] raw;
		int               gap;
		bit               drain;
	} reading_t;

	typedef struct {
		logic [RAW_W-1:0] distance;
		logic             below;
		logic             sat;
	} calibrated_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [RAW_W-1:0] raw_distance = '0;
	logic             busy;
	logic             done;
	logic [RAW_W-1:0] true_distance;
	logic             below_range;
	logic             saturated;

	reading_t    pending_readings[$];
	calibrated_t expected_cal[$];
	reading_t    cur_reading;
	bit          have_reading = 1'b0;
	bit          taken = 1'b0;
	int          gap_left = 0;
	int          mismatch_count = 0;

	range_calibration_interp i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.raw_distance  (raw_distance),
		.done          (done),
		.true_distance (true_distance),
		.below_range   (below_range),
		.saturated     (saturated)
	);

	function automatic calibrated_t predict_calibration(logic [RAW_W-1:0] raw);
		calibrated_t res;
		int unsigned r;
		int unsigned seg;
		int unsigned value;
		r = 32'(raw);
		res.below = 1'b0;
		res.sat = 1'b0;
		if (r < CAL_RAW[0]) begin
			value = CAL_TRUE[0];
			res.below = 1'b1;
		end else begin
			seg = CAL_POINTS - 2;
			for (int i = 0; i < CAL_POINTS - 1; i++) begin
				if (r < CAL_RAW[i+1]) begin
					seg = i;
					break;
				end
			end
			value = ((r - CAL_RAW[seg]) * (CAL_TRUE[seg+1] - CAL_TRUE[seg]))
				/ (CAL_RAW[seg+1] - CAL_RAW[seg]) + CAL_TRUE[seg];
		end
		if (value > OUT_LIMIT) begin
			value = OUT_LIMIT;
			res.sat = 1'b1;
		end
		res.distance = value[RAW_W-1:0];
		return res;
	endfunction

	task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
		$display("MISMATCH at %0t: %s expected %0d got %0d", $realtime, what, exp_val, got_val);
		mismatch_count++;
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Items are driven at the falling edge; a new item follows a taken one
	// without dropping start when its gap is zero and it is not a drain item.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (!(start && !taken)) begin
			if (!have_reading && pending_readings.size() != 0) begin
				cur_reading = pending_readings.pop_front();
				have_reading = 1'b1;
				gap_left = cur_reading.gap;
			end
			if (!have_reading) begin
				start <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (cur_reading.drain && expected_cal.size() != 0) begin
				start <= 1'b0;
			end else begin
				start <= 1'b1;
				raw_distance <= cur_reading.raw;
				have_reading = 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		calibrated_t exp_res;
		if (done) begin
			if (expected_cal.size() == 0) begin
				report_mismatch("unexpected result, true_distance", 0, 32'(true_distance));
			end else begin
				exp_res = expected_cal.pop_front();
				if (true_distance !== exp_res.distance)
					report_mismatch("true_distance", 32'(exp_res.distance),
						32'(true_distance));
				if (below_range !== exp_res.below)
					report_mismatch("below_range", 32'(exp_res.below), 32'(below_range));
				if (saturated !== exp_res.sat)
					report_mismatch("saturated", 32'(exp_res.sat), 32'(saturated));
			end
		end
		taken = arst_n && start && !busy;
		if (taken)
			expected_cal.push_back(predict_calibration(raw_distance));
	end

	initial begin
		reading_t rd;
		int sel;
		int idx;
		bit no_idle;
		for (int i = 0; i < DIRECTED_COUNT; i++) begin
			rd.raw = RAW_W'(DIRECTED_RAW[i]);
			rd.gap = (i % 3 == 0) ? $urandom_range(0, 15) : 0;
			rd.drain = 1'b0;
			pending_readings.push_back(rd);
		end
		no_idle = 1'b0;
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			if (i % 100 == 0)
				no_idle = ($urandom_range(0, 2) == 0);
			sel = $urandom_range(0, 9);
			if (sel <= 3) begin
				rd.raw = RAW_W'($urandom_range(131, 700));
			end else if (sel <= 5) begin
				idx = $urandom_range(0, CAL_POINTS - 1);
				rd.raw = RAW_W'(CAL_RAW[idx] + $urandom_range(0, 2) - 1);
			end else if (sel == 6) begin
				rd.raw = RAW_W'($urandom_range(0, 130));
			end else if (sel == 7) begin
				rd.raw = RAW_W'($urandom_range(6900, 7200));
			end else begin
				rd.raw = RAW_W'($urandom_range(0, 65535));
			end
			rd.gap = no_idle ? 0 : $urandom_range(0, 15);
			rd.drain = (i % 300 == 0);
			pending_readings.push_back(rd);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_readings.size() != 0 || have_reading || start)
			@(posedge clk);
		while (expected_cal.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);

		if (mismatch_count == 0 && expected_cal.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#5000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
